// ----- rtl/mrrcs_pkg.sv -----
// Shared types and constants for the multicast round-robin crossbar scheduler.
// Holds matrix geometry, register codes and the grant result struct.
// No dependencies.
package mrrcs_pkg;

   localparam int DEFAULT_INPUTS  = 8;
   localparam int DEFAULT_OUTPUTS = 8;

   // Request and grant matrices use a fixed row stride of eight bits.
   localparam int LANE_W     = 8;
   localparam int MATRIX_W   = 64;
   localparam int PTR_W      = 3;
   localparam int COUNT_W    = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [COUNT_W-1:0] ACTIVE_INPUTS_RESET = 4'd8;

   typedef enum logic [0:0] {
      CSR_ACTIVE_INPUTS = 1'b0
   } csr_index_type;

   typedef struct packed {
      logic [MATRIX_W-1:0] grants;
      logic [PTR_W-1:0]    next_pointer;
   } grant_result_type;

endpackage

// ----- rtl/mrrcs_grant_unit.sv -----
// Combinational grant logic for one scheduling round.
// Depends on mrrcs_pkg for matrix geometry and the grant result struct.
module mrrcs_grant_unit #(
   parameter int INPUTS  = mrrcs_pkg::DEFAULT_INPUTS,
   parameter int OUTPUTS = mrrcs_pkg::DEFAULT_OUTPUTS
) (
   input  logic [mrrcs_pkg::MATRIX_W-1:0] requests_i,
   input  logic [mrrcs_pkg::PTR_W-1:0]    pointer_i,
   input  logic [mrrcs_pkg::COUNT_W-1:0]  active_inputs_i,
   output mrrcs_pkg::grant_result_type    result_o
);
   import mrrcs_pkg::*;

   logic [COUNT_W-1:0] count;
   logic [COUNT_W-1:0] start;
   logic [INPUTS-1:0]  active_mask;
   logic [INPUTS-1:0]  after_mask;
   logic [INPUTS-1:0]  any_req;
   logic [MATRIX_W-1:0] grants;

   // Out-of-range counts clamp to the legal range.
   always_comb begin
      if (active_inputs_i == '0) begin
         count = COUNT_W'(1);
      end else if (active_inputs_i > COUNT_W'(INPUTS)) begin
         count = COUNT_W'(INPUTS);
      end else begin
         count = active_inputs_i;
      end
   end

   // The pointer may exceed the count after the count shrinks; reduce it.
   always_comb begin
      start = {1'b0, pointer_i};
      for (int s = 0; s < LANE_W - 1; s++) begin
         if (start >= count) begin
            start = start - count;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < INPUTS; i++) begin
         active_mask[i] = COUNT_W'(i) < count;
         after_mask[i]  = COUNT_W'(i) >= start;
      end
   end

   // Each output takes the lowest requester at or after the pointer, else
   // wraps to the lowest requester overall.
   always_comb begin
      logic [INPUTS-1:0] col;
      logic [INPUTS-1:0] hi;
      logic [INPUTS-1:0] pick;
      grants  = '0;
      any_req = '0;
      for (int o = 0; o < OUTPUTS; o++) begin
         for (int i = 0; i < INPUTS; i++) begin
            col[i] = requests_i[i*LANE_W + o] & active_mask[i];
         end
         hi   = col & after_mask;
         pick = (hi != '0) ? (hi & (~hi + 1'b1)) : (col & (~col + 1'b1));
         grants[o*LANE_W +: INPUTS] = pick;
         any_req = any_req | col;
      end
   end

   // The granted input nearest the pointer is the first input with any
   // request, so the pointer update searches the union of all requests.
   always_comb begin
      logic [INPUTS-1:0]  hi;
      logic [INPUTS-1:0]  first;
      logic [COUNT_W-1:0] base;
      logic [COUNT_W-1:0] incr;
      hi    = any_req & after_mask;
      first = (hi != '0) ? (hi & (~hi + 1'b1)) : (any_req & (~any_req + 1'b1));
      base  = start;
      for (int i = 0; i < INPUTS; i++) begin
         if (first[i]) begin
            base = COUNT_W'(i);
         end
      end
      incr = base + COUNT_W'(1);
      if (incr >= count) begin
         incr = '0;
      end
      result_o.grants       = grants;
      result_o.next_pointer = incr[PTR_W-1:0];
   end

endmodule

// ----- rtl/multicast_round_robin_crossbar_scheduler.sv -----
// A beat accepted into the input register moves through the result register to rsp_.
// Throughput: one beat per cycle unless rsp_ready stalls; the shared pointer loop
// closes within the grant logic between the input register and the result register.
// req_ready follows rsp_ready combinationally while both stages are full.
// Reset (synchronous, active high) empties both stages, clears the pointer
// to zero and sets active_inputs to eight.
module multicast_round_robin_crossbar_scheduler #(
   parameter int INPUTS  = mrrcs_pkg::DEFAULT_INPUTS,
   parameter int OUTPUTS = mrrcs_pkg::DEFAULT_OUTPUTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mrrcs_pkg::MATRIX_W-1:0]    req_requests,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mrrcs_pkg::MATRIX_W-1:0]    rsp_grant_matrix,
   output logic [mrrcs_pkg::PTR_W-1:0]       rsp_next_pointer,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mrrcs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [mrrcs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mrrcs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import mrrcs_pkg::*;

   // The input stage holds the request matrix of one round. The result stage
   // holds the grants of the previous round, so a new beat can enter while a
   // finished result still waits for the consumer.
   logic                 in_valid_ff,  in_valid_in;
   logic [MATRIX_W-1:0]  requests_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [MATRIX_W-1:0]  grants_ff;
   logic [PTR_W-1:0]     next_ptr_ff;
   logic [PTR_W-1:0]     pointer_ff,   pointer_in;
   logic [COUNT_W-1:0]   active_ff,    active_in;

   logic             out_open;
   logic             advance;
   logic             accept;
   logic             csr_write;
   csr_index_type    csr_index;
   grant_result_type result;

   mrrcs_grant_unit #(
      .INPUTS  (INPUTS),
      .OUTPUTS (OUTPUTS)
   ) u_grant (
      .requests_i      (requests_ff),
      .pointer_i       (pointer_ff),
      .active_inputs_i (active_ff),
      .result_o        (result)
   );

   // The result stage frees up when it is empty or its beat is being taken.
   assign out_open  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_open;
   assign req_ready = !in_valid_ff || out_open;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      pointer_in   = pointer_ff;
      if (out_open) begin
         out_valid_in = in_valid_ff;
      end
      if (advance) begin
         in_valid_in = 1'b0;
         // The pointer moves exactly once per round, when its grants leave
         // the input stage, so the next round already sees the update.
         pointer_in  = result.next_pointer;
      end
      if (accept) begin
         in_valid_in = 1'b1;
      end
   end

   // Configuration port. Writes complete in the access phase; pready is tied
   // high, so no access is extended by wait states.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1]);

   always_comb begin
      active_in = active_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ACTIVE_INPUTS: active_in = csr_pwdata[COUNT_W-1:0];
            default: active_in = active_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_ACTIVE_INPUTS: csr_prdata = CSR_DATA_W'(active_ff);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pointer_ff   <= '0;
         active_ff    <= ACTIVE_INPUTS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pointer_ff   <= pointer_in;
         active_ff    <= active_in;
      end
   end

   // Payload registers carry no reset; their valid bits guard them.
   always_ff @(posedge clock) begin
      if (accept) begin
         requests_ff <= req_requests;
      end
      if (advance) begin
         grants_ff   <= result.grants;
         next_ptr_ff <= result.next_pointer;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_grant_matrix = grants_ff;
   assign rsp_next_pointer = next_ptr_ff;

endmodule

// ----- rtl/mrrcs_checker.sv -----
// Port-level assertions for the multicast round-robin crossbar scheduler.
// Depends on mrrcs_pkg; bound to the top level at the end of this file.
module mrrcs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [mrrcs_pkg::MATRIX_W-1:0] rsp_grant_matrix,
   input logic [mrrcs_pkg::PTR_W-1:0]    rsp_next_pointer
);
   import mrrcs_pkg::*;

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_grant_matrix) && $stable(rsp_next_pointer))
      else $error("stalled result beat changed");

   // Each output grants at most one input.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         $onehot0(rsp_grant_matrix[7:0])   && $onehot0(rsp_grant_matrix[15:8])  &&
         $onehot0(rsp_grant_matrix[23:16]) && $onehot0(rsp_grant_matrix[31:24]) &&
         $onehot0(rsp_grant_matrix[39:32]) && $onehot0(rsp_grant_matrix[47:40]) &&
         $onehot0(rsp_grant_matrix[55:48]) && $onehot0(rsp_grant_matrix[63:56]))
      else $error("output granted more than one input");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A beat accepted with the result side empty passes the input and result registers to rsp_valid.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
      else $error("accepted beat did not reach the result side");

endmodule

bind multicast_round_robin_crossbar_scheduler mrrcs_checker u_checker (.*);

// ----- verif/multicast_round_robin_crossbar_scheduler_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the multicast round-robin crossbar scheduler.
// Needs only mrrcs_pkg and the scheduler RTL; it predicts every grant beat itself.
module multicast_round_robin_crossbar_scheduler_test;
   import mrrcs_pkg::*;

   localparam int NUM_INPUTS  = DEFAULT_INPUTS;
   localparam int NUM_OUTPUTS = DEFAULT_OUTPUTS;

   // A beat taken passes the input register and the result register on its way to the result side.
   localparam int PIPE_LATENCY = 2;

   // Cycles with work outstanding but no beat moving before the run is abandoned.
   // Both sides idle far less often than this even in their worst stretches.
   localparam int STALL_LIMIT = 2000;

   // The register map only has the active input count at index zero. Index one
   // is unmapped and is used to check that stray writes are dropped.
   localparam int UNMAPPED_INDEX = 1;
   localparam logic [CSR_ADDR_W-1:0] ACTIVE_ADDR   = CSR_ADDR_W'(int'(CSR_ACTIVE_INPUTS) * 4);
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = CSR_ADDR_W'(UNMAPPED_INDEX * 4);

   // Idle rates in percent for the three traffic modes.
   localparam int LIGHT_IDLE = 7;
   localparam int HEAVY_IDLE = 62;

   localparam int SEGMENTS         = 12;
   localparam int ROUNDS_PER_SEG   = 75;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [MATRIX_W-1:0]    req_requests;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [MATRIX_W-1:0]    rsp_grant_matrix;
   logic [PTR_W-1:0]       rsp_next_pointer;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // Request matrices waiting for the driver, and grant beats the block owes us.
   logic [MATRIX_W-1:0]    request_backlog[$];
   grant_result_type       pending_grants[$];

   // Our own copy of the scheduler state and of its one register.
   logic [COUNT_W-1:0]     active_count;
   logic [PTR_W-1:0]       shared_pointer;

   int                     send_idle_pct;
   int                     recv_idle_pct;
   int                     queued_rounds;
   int                     accepted_rounds;
   int                     error_count;
   int                     stall_cycles;
   bit                     req_taken;

   multicast_round_robin_crossbar_scheduler i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_requests     (req_requests),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_grant_matrix (rsp_grant_matrix),
      .rsp_next_pointer (rsp_next_pointer),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #5 clock = ~clock;

   // One scheduling round. Every output walks the active inputs starting at the
   // shared pointer and grants the first one that wants it. The pointer then
   // lands one past the granted input closest to it, or simply steps by one when
   // nothing was granted. A count of zero behaves as one and anything above the
   // number of inputs behaves as the full width, so the search range is clamped
   // first; a pointer left over from a wider setting is folded into range.
   function automatic grant_result_type schedule_round(logic [MATRIX_W-1:0] requests);
      grant_result_type result;
      int               span;
      int               start;
      int               nearest;
      int               candidate;
      bit               found;
      span = int'(active_count);
      if (span == 0) begin
         span = 1;
      end
      if (span > NUM_INPUTS) begin
         span = NUM_INPUTS;
      end
      start   = int'(shared_pointer) % span;
      nearest = span;
      result.grants = '0;
      for (int out_idx = 0; out_idx < NUM_OUTPUTS; out_idx++) begin
         found = 1'b0;
         for (int step = 0; step < span; step++) begin
            candidate = (start + step) % span;
            if (!found && requests[candidate*LANE_W + out_idx]) begin
               result.grants[out_idx*LANE_W + candidate] = 1'b1;
               if (step < nearest) begin
                  nearest = step;
               end
               found = 1'b1;
            end
         end
      end
      shared_pointer      = PTR_W'((start + nearest + 1) % span);
      result.next_pointer = shared_pointer;
      return result;
   endfunction

   // Random request matrices. Half the rounds look like real queue heads: sparse
   // fanouts on the active inputs only. The rest is dense noise, empty rounds
   // and lone bits anywhere, including rows and columns that must be ignored.
   function automatic logic [MATRIX_W-1:0] random_requests();
      logic [MATRIX_W-1:0] requests;
      int                  kind;
      requests = '0;
      kind     = $urandom_range(9);
      if (kind == 0) begin
         requests = '0;
      end else if (kind <= 2) begin
         requests = {$urandom(), $urandom()};
      end else if (kind <= 7) begin
         for (int in_idx = 0; in_idx < NUM_INPUTS; in_idx++) begin
            if (in_idx < int'(active_count) && $urandom_range(2) == 0) begin
               requests[in_idx*LANE_W +: LANE_W] = LANE_W'($urandom());
            end
         end
      end else begin
         requests[$urandom_range(MATRIX_W-1)] = 1'b1;
      end
      return requests;
   endfunction

   task automatic queue_round(logic [MATRIX_W-1:0] requests);
      request_backlog.push_back(requests);
      queued_rounds++;
   endtask

   // Waits until every queued round has been taken and answered. The monitor touches
   // its counters only at rising edges, so reading them at falling edges is safe.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (accepted_rounds != queued_rounds || pending_grants.size() != 0);
      repeat (PIPE_LATENCY) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // Only the low nibble of the count register is kept.
      if (addr == ACTIVE_ADDR) begin
         active_count = data[COUNT_W-1:0];
      end
   endtask

   task automatic csr_check_count();
      logic [CSR_DATA_W-1:0] want;
      want = CSR_DATA_W'(active_count);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= ACTIVE_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want) begin
         $display("%0t: active_inputs readback expected %h actual %h", $realtime, want,
                  csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Driver: a beat stays on the bus until it is taken; after that the next
   // matrix goes out unless the sender decides to idle this cycle.
   always @(negedge clock) begin
      if (!(req_valid && !req_taken)) begin
         if (!reset && request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
         begin
            req_valid    <= 1'b1;
            req_requests <= request_backlog.pop_front();
         end else begin
            req_valid    <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: results are retired before new rounds are predicted, so a stray
   // beat can never be matched against the round that was taken at the same edge.
   always @(posedge clock) begin
      grant_result_type want;
      bit               moved;
      if (reset) begin
         req_taken    = 1'b0;
         stall_cycles = 0;
      end else begin
         moved = 1'b0;
         if (rsp_valid === 1'b1 && rsp_ready) begin
            moved = 1'b1;
            if (pending_grants.size() == 0) begin
               $display("%0t: unexpected beat expected none actual grants %h pointer %h",
                        $realtime, rsp_grant_matrix, rsp_next_pointer);
               error_count++;
            end else begin
               want = pending_grants.pop_front();
               if (rsp_grant_matrix !== want.grants) begin
                  $display("%0t: grant_matrix expected %h actual %h", $realtime,
                           want.grants, rsp_grant_matrix);
                  error_count++;
               end
               if (rsp_next_pointer !== want.next_pointer) begin
                  $display("%0t: next_pointer expected %h actual %h", $realtime,
                           want.next_pointer, rsp_next_pointer);
                  error_count++;
               end
            end
         end
         req_taken = req_valid && (req_ready === 1'b1);
         if (req_taken) begin
            moved = 1'b1;
            pending_grants.push_back(schedule_round(req_requests));
            accepted_rounds++;
         end
         // Only count cycles in which something is owed and nothing moves.
         if (moved || csr_psel) begin
            stall_cycles = 0;
         end else if (req_valid || pending_grants.size() != 0 || request_backlog.size() != 0)
         begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("%0t: no beat moved for %0d cycles", $realtime, stall_cycles);
               $display("Some tests failed");
               $finish;
            end
         end
      end
   end

   initial begin
      logic [3:0] count_plan[SEGMENTS];
      logic [3:0] next_count;
      int         remaining;
      int         batch;
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_requests    = '0;
      rsp_ready       = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      active_count    = ACTIVE_INPUTS_RESET;
      shared_pointer  = '0;
      queued_rounds   = 0;
      accepted_rounds = 0;
      error_count     = 0;
      stall_cycles    = 0;
      req_taken       = 1'b0;
      send_idle_pct   = LIGHT_IDLE;
      recv_idle_pct   = HEAVY_IDLE;
      // Sweeps from a single input to the full width, through a zero count,
      // the all-ones nibble and a value just past the number of inputs.
      count_plan = '{4'd3, 4'd1, 4'd0, 4'd8, 4'd15, 4'd9, 4'd5, 4'd2, 4'd7, 4'd6, 4'd4, 4'd8};
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed rounds at the reset width of eight inputs.
      csr_check_count();
      queue_round('0);
      queue_round('1);
      queue_round(64'h0000_0000_0000_0001);
      queue_round(64'h8000_0000_0000_0000);
      queue_round(64'hAAAA_AAAA_AAAA_AAAA);
      queue_round(64'h5555_5555_5555_5555);
      queue_round(64'h0101_0101_0101_0101);
      queue_round(64'h8080_8080_8080_8080);
      queue_round(64'h0000_0000_0000_00FF);
      queue_round(64'hFF00_0000_0000_0000);
      queue_round(64'h0000_0010_0000_0000);
      queue_round(64'h0102_0408_1020_4080);
      queue_round(64'h8040_2010_0804_0201);
      queue_round(64'h0000_0000_0000_0000);
      queue_round(64'h00FF_00FF_00FF_00FF);
      // Input six alone leaves the pointer at seven, so the narrower setting
      // that follows starts with a pointer outside its range.
      queue_round(64'h0001_0000_0000_0000);
      wait_drained();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 4) begin
            send_idle_pct = HEAVY_IDLE;
            recv_idle_pct = LIGHT_IDLE;
         end else if (seg == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         next_count = (seg == SEGMENTS - 1) ? 4'($urandom_range(15)) : count_plan[seg];
         // Upper data bits carry junk; the register must keep only the nibble.
         csr_write(ACTIVE_ADDR, ($urandom() & 32'hFFFF_FFF0) | CSR_DATA_W'(next_count));
         if (seg % 5 == 2) begin
            csr_write(UNMAPPED_ADDR, $urandom());
         end
         csr_check_count();

         remaining = ROUNDS_PER_SEG;
         while (remaining > 0) begin
            batch = $urandom_range(30, 1);
            if (batch > remaining) begin
               batch = remaining;
            end
            repeat (batch) queue_round(random_requests());
            remaining -= batch;
            // Now and then hold back until the block has answered everything.
            if ($urandom_range(3) == 0) begin
               wait_drained();
            end else begin
               do begin
                  @(negedge clock);
               end while (request_backlog.size() > 2);
            end
         end
         wait_drained();
      end

      repeat (PIPE_LATENCY + 4) @(negedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
